/* src/ppsp_pkg.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser package
// Shared constants, codes and types for the byte-stream PPM header and pixel
// parser.
// ----------------------------------------------------------------------------
package ppsp_pkg;

  // Largest accepted image width or height.
  localparam int unsigned MaxDim = 4096;
  // Value at which a decimal magnitude saturates while it is gathered.
  localparam int unsigned NumCap = (MaxDim > 255) ? (MaxDim + 1) : 256;
  // Largest accepted maximum colour value.
  localparam int unsigned MaxColour = 255;

  // Field widths of the result item.
  localparam int unsigned DimW   = 13;
  localparam int unsigned PosW   = 12;
  localparam int unsigned AccW   = 13;
  // Width of the multiply-accumulate result for one decimal digit.
  localparam int unsigned MacW   = AccW + 4;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes used by the header syntax.
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSix   = 8'h36;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_NUMBER = 2'd1,
    ERR_MAXVAL = 2'd2
  } err_e;

  // Parser phase, one-hot.
  typedef enum logic [13:0] {
    PH_MAG_P   = 14'b00000000000001,
    PH_MAG_6   = 14'b00000000000010,
    PH_MAG_END = 14'b00000000000100,
    PH_W_START = 14'b00000000001000,
    PH_W_SIGN  = 14'b00000000010000,
    PH_W_DIG   = 14'b00000000100000,
    PH_H_START = 14'b00000001000000,
    PH_H_SIGN  = 14'b00000010000000,
    PH_H_DIG   = 14'b00000100000000,
    PH_M_START = 14'b00001000000000,
    PH_M_SIGN  = 14'b00010000000000,
    PH_M_DIG   = 14'b00100000000000,
    PH_PIXEL   = 14'b01000000000000,
    PH_HALT    = 14'b10000000000000
  } phase_e;

  // A classified input byte as it travels from the front to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       is_ws;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_sign;
    logic       is_minus;
    logic       is_p;
    logic       is_six;
  } byte_cls_t;

endpackage

/* src/ppsp_if.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser channels
// Valid/ready channels for the input bytes and the result items.
// ----------------------------------------------------------------------------

// Input byte channel.
interface ppsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink (input valid, input in_byte, input restart, output ready);
endinterface

// Result channel.
interface ppsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [7:0]  max_value;
  logic [11:0] pixel_row;
  logic [11:0] pixel_column;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [2:0]  keep_mask;
  logic        last_pixel;
  logic [1:0]  error_code;

  modport source (
    output valid, output result_kind, output image_width, output image_height,
    output max_value, output pixel_row, output pixel_column, output red,
    output green, output blue, output keep_mask, output last_pixel,
    output error_code, input ready
  );
  modport sink (
    input valid, input result_kind, input image_width, input image_height,
    input max_value, input pixel_row, input pixel_column, input red,
    input green, input blue, input keep_mask, input last_pixel,
    input error_code, output ready
  );
endinterface

/* src/ppsp_front.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser front end
// Accepts input bytes and classifies each one for the parser back end.
// ----------------------------------------------------------------------------
module ppsp_front (
  ppsp_in_if.sink             in_i,
  output logic                push_valid_o,
  output ppsp_pkg::byte_cls_t push_data_o,
  input  logic                push_ready_i
);

  logic [7:0] b;

  assign b = in_i.in_byte;

  // The front accepts a byte whenever the queue has room for it.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // Character classification: whitespace, digits, signs and magic letters.
  always_comb begin
    push_data_o          = '0;
    push_data_o.data     = b;
    push_data_o.restart  = in_i.restart;
    push_data_o.is_ws    = (b == ppsp_pkg::ChSpace) ||
                           ((b >= ppsp_pkg::ChTab) && (b <= ppsp_pkg::ChCr));
    push_data_o.is_digit = (b >= ppsp_pkg::ChZero) && (b <= ppsp_pkg::ChNine);
    push_data_o.digit    = 4'(b - ppsp_pkg::ChZero);
    push_data_o.is_sign  = (b == ppsp_pkg::ChPlus) || (b == ppsp_pkg::ChMinus);
    push_data_o.is_minus = (b == ppsp_pkg::ChMinus);
    push_data_o.is_p     = (b == ppsp_pkg::ChP);
    push_data_o.is_six   = (b == ppsp_pkg::ChSix);
  end

endmodule

/* src/ppsp_queue.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser queue
// Short first-in first-out queue of classified bytes between the front and
// back ends, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ppsp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  ppsp_pkg::byte_cls_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output ppsp_pkg::byte_cls_t pop_data_o,
  input  logic                pop_ready_i
);

  ppsp_pkg::byte_cls_t                    mem_q [ppsp_pkg::QueueDepth];
  logic [ppsp_pkg::QueuePtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [ppsp_pkg::QueuePtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [ppsp_pkg::QueueCntW-1:0]         count_q, count_d;
  logic                                   push, pop;

  assign push_ready_o = (count_q != ppsp_pkg::QueueCntW'(ppsp_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ppsp_pkg::QueuePtrW'(ppsp_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ppsp_pkg::QueuePtrW'(ppsp_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/ppsp_back.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser back end
// Runs the header and pixel state machine on classified bytes and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module ppsp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  ppsp_pkg::byte_cls_t pop_data_i,
  output logic                pop_ready_o,
  ppsp_out_if.source          out_o
);

  ppsp_pkg::phase_e                phase_q, phase_d, cur_phase;
  logic [ppsp_pkg::AccW-1:0]       acc_q, acc_d;
  logic                            neg_q, neg_d;
  logic [ppsp_pkg::DimW-1:0]       width_q, width_d;
  logic [ppsp_pkg::DimW-1:0]       height_q, height_d;
  logic [7:0]                      maxval_q, maxval_d;
  logic [ppsp_pkg::PosW-1:0]       row_q, row_d;
  logic [ppsp_pkg::PosW-1:0]       col_q, col_d;
  logic [1:0]                      chan_q, chan_d;
  logic [7:0]                      red_q, red_d;
  logic [7:0]                      green_q, green_d;

  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      kind_q, kind_d;
  logic [ppsp_pkg::DimW-1:0]       o_width_q, o_width_d;
  logic [ppsp_pkg::DimW-1:0]       o_height_q, o_height_d;
  logic [7:0]                      o_maxval_q, o_maxval_d;
  logic [ppsp_pkg::PosW-1:0]       o_row_q, o_row_d;
  logic [ppsp_pkg::PosW-1:0]       o_col_q, o_col_d;
  logic [7:0]                      o_red_q, o_red_d;
  logic [7:0]                      o_green_q, o_green_d;
  logic [7:0]                      o_blue_q, o_blue_d;
  logic [2:0]                      o_mask_q, o_mask_d;
  logic                            o_last_q, o_last_d;
  logic [1:0]                      o_err_q, o_err_d;

  logic                            pop, fire;
  logic [ppsp_pkg::MacW-1:0]       mac;
  logic [ppsp_pkg::AccW-1:0]       acc_sat;
  logic                            dim_bad, max_bad;
  logic                            do_start;
  logic [1:0]                      start_field;
  ppsp_pkg::phase_e                ph_start, ph_sign, ph_dig;
  logic [ppsp_pkg::DimW-1:0]       row_inc, col_inc;
  logic                            row_end, col_end;
  ppsp_pkg::byte_cls_t             c;

  assign c = pop_data_i;

  // The back end takes a byte when the output register is free or draining.
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // A restart puts the parser back at the magic before this byte is used.
  assign cur_phase = c.restart ? ppsp_pkg::PH_MAG_P : phase_q;

  // Decimal accumulation with saturation.
  assign mac     = ppsp_pkg::MacW'(acc_q) * ppsp_pkg::MacW'(10) + ppsp_pkg::MacW'(c.digit);
  assign acc_sat = (mac > ppsp_pkg::MacW'(ppsp_pkg::NumCap)) ?
                   ppsp_pkg::AccW'(ppsp_pkg::NumCap) : mac[ppsp_pkg::AccW-1:0];

  // Range checks on a completed number.
  assign dim_bad = neg_q || (acc_q == '0) || (acc_q > ppsp_pkg::AccW'(ppsp_pkg::MaxDim));
  assign max_bad = neg_q || (acc_q == '0) ||
                   (acc_q > ppsp_pkg::AccW'(ppsp_pkg::MaxColour));

  // Pixel position bookkeeping.
  assign row_inc = ppsp_pkg::DimW'(row_q) + 1'b1;
  assign col_inc = ppsp_pkg::DimW'(col_q) + 1'b1;
  assign row_end = (row_inc >= height_q);
  assign col_end = (col_inc >= width_q);

  // Phases belonging to the field whose start is being handled.
  always_comb begin
    unique case (start_field)
      2'd0: begin
        ph_start = ppsp_pkg::PH_W_START;
        ph_sign  = ppsp_pkg::PH_W_SIGN;
        ph_dig   = ppsp_pkg::PH_W_DIG;
      end
      2'd1: begin
        ph_start = ppsp_pkg::PH_H_START;
        ph_sign  = ppsp_pkg::PH_H_SIGN;
        ph_dig   = ppsp_pkg::PH_H_DIG;
      end
      default: begin
        ph_start = ppsp_pkg::PH_M_START;
        ph_sign  = ppsp_pkg::PH_M_SIGN;
        ph_dig   = ppsp_pkg::PH_M_DIG;
      end
    endcase
  end

  // Parser state machine, one byte per cycle while the output register is free or draining.
  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    width_d     = width_q;
    height_d    = height_q;
    maxval_d    = maxval_q;
    row_d       = row_q;
    col_d       = col_q;
    chan_d      = chan_q;
    red_d       = red_q;
    green_d     = green_q;
    do_start    = 1'b0;
    start_field = 2'd0;
    fire        = 1'b0;
    kind_d      = kind_q;
    o_width_d   = o_width_q;
    o_height_d  = o_height_q;
    o_maxval_d  = o_maxval_q;
    o_row_d     = o_row_q;
    o_col_d     = o_col_q;
    o_red_d     = o_red_q;
    o_green_d   = o_green_q;
    o_blue_d    = o_blue_q;
    o_mask_d    = o_mask_q;
    o_last_d    = o_last_q;
    o_err_d     = o_err_q;

    if (pop) begin
      // Error results carry only the kind and the code.
      o_width_d  = '0;
      o_height_d = '0;
      o_maxval_d = '0;
      o_row_d    = '0;
      o_col_d    = '0;
      o_red_d    = '0;
      o_green_d  = '0;
      o_blue_d   = '0;
      o_mask_d   = '0;
      o_last_d   = 1'b0;
      o_err_d    = '0;
      kind_d     = ppsp_pkg::KIND_ERROR;

      unique case (cur_phase) inside
        ppsp_pkg::PH_MAG_P: begin
          phase_d = ppsp_pkg::PH_MAG_P;
          if (c.is_p) begin
            phase_d = ppsp_pkg::PH_MAG_6;
          end else if (!c.is_ws) begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_MAGIC;
          end
        end
        ppsp_pkg::PH_MAG_6: begin
          if (c.is_six) begin
            phase_d = ppsp_pkg::PH_MAG_END;
          end else begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_MAGIC;
          end
        end
        ppsp_pkg::PH_MAG_END: begin
          if (c.is_ws) begin
            phase_d = ppsp_pkg::PH_W_START;
          end else begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_MAGIC;
          end
        end
        ppsp_pkg::PH_W_START: begin
          do_start    = 1'b1;
          start_field = 2'd0;
        end
        ppsp_pkg::PH_H_START: begin
          do_start    = 1'b1;
          start_field = 2'd1;
        end
        ppsp_pkg::PH_M_START: begin
          do_start    = 1'b1;
          start_field = 2'd2;
        end
        ppsp_pkg::PH_W_SIGN, ppsp_pkg::PH_H_SIGN, ppsp_pkg::PH_M_SIGN: begin
          // A sign must be followed by at least one digit.
          if (c.is_digit) begin
            acc_d = acc_sat;
            if (cur_phase == ppsp_pkg::PH_W_SIGN) begin
              phase_d = ppsp_pkg::PH_W_DIG;
            end else if (cur_phase == ppsp_pkg::PH_H_SIGN) begin
              phase_d = ppsp_pkg::PH_H_DIG;
            end else begin
              phase_d = ppsp_pkg::PH_M_DIG;
            end
          end else begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_NUMBER;
          end
        end
        ppsp_pkg::PH_W_DIG: begin
          if (c.is_digit) begin
            acc_d = acc_sat;
          end else if (dim_bad) begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_NUMBER;
          end else begin
            // The ending byte also opens the height field.
            width_d     = acc_q;
            do_start    = 1'b1;
            start_field = 2'd1;
          end
        end
        ppsp_pkg::PH_H_DIG: begin
          if (c.is_digit) begin
            acc_d = acc_sat;
          end else if (dim_bad) begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_NUMBER;
          end else begin
            height_d    = acc_q;
            do_start    = 1'b1;
            start_field = 2'd2;
          end
        end
        ppsp_pkg::PH_M_DIG: begin
          if (c.is_digit) begin
            acc_d = acc_sat;
          end else if (max_bad) begin
            fire    = 1'b1;
            o_err_d = ppsp_pkg::ERR_MAXVAL;
          end else begin
            // The ending byte is the separator; the header is reported here.
            maxval_d   = acc_q[7:0];
            row_d      = '0;
            col_d      = '0;
            chan_d     = '0;
            phase_d    = ppsp_pkg::PH_PIXEL;
            fire       = 1'b1;
            kind_d     = ppsp_pkg::KIND_HEADER;
            o_width_d  = width_q;
            o_height_d = height_q;
            o_maxval_d = acc_q[7:0];
          end
        end
        ppsp_pkg::PH_PIXEL: begin
          if (chan_q == 2'd0) begin
            red_d  = c.data;
            chan_d = 2'd1;
          end else if (chan_q == 2'd1) begin
            green_d = c.data;
            chan_d  = 2'd2;
          end else begin
            fire       = 1'b1;
            kind_d     = ppsp_pkg::KIND_PIXEL;
            o_width_d  = width_q;
            o_height_d = height_q;
            o_maxval_d = maxval_q;
            o_row_d    = row_q;
            o_col_d    = col_q;
            o_red_d    = red_q;
            o_green_d  = green_q;
            o_blue_d   = c.data;
            o_mask_d   = {c.data <= maxval_q, green_q <= maxval_q, red_q <= maxval_q};
            o_last_d   = row_end && col_end;
            chan_d     = 2'd0;
            if (row_end && col_end) begin
              phase_d = ppsp_pkg::PH_HALT;
            end else if (col_end) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
        ppsp_pkg::PH_HALT: begin
          phase_d = ppsp_pkg::PH_HALT;
        end
        default: begin
          phase_d = ppsp_pkg::PH_HALT;
        end
      endcase

      // Start of a numeric field: whitespace, a sign or the first digit.
      if (do_start) begin
        if (c.is_ws) begin
          phase_d = ph_start;
        end else if (c.is_sign) begin
          neg_d   = c.is_minus;
          acc_d   = '0;
          phase_d = ph_sign;
        end else if (c.is_digit) begin
          neg_d   = 1'b0;
          acc_d   = ppsp_pkg::AccW'(c.digit);
          phase_d = ph_dig;
        end else begin
          fire    = 1'b1;
          o_err_d = ppsp_pkg::ERR_NUMBER;
        end
      end

      // Any error leaves the parser halted until restart.
      if (fire && (kind_d == ppsp_pkg::KIND_ERROR)) begin
        phase_d = ppsp_pkg::PH_HALT;
      end
    end

    out_valid_d = (pop && fire) || (out_valid_q && !out_o.ready);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ppsp_pkg::PH_MAG_P;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      maxval_q    <= 8'd1;
      row_q       <= '0;
      col_q       <= '0;
      chan_q      <= '0;
      red_q       <= '0;
      green_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      width_q     <= width_d;
      height_q    <= height_d;
      maxval_q    <= maxval_d;
      row_q       <= row_d;
      col_q       <= col_d;
      chan_q      <= chan_d;
      red_q       <= red_d;
      green_q     <= green_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register, loaded only when a new result is produced.
  always_ff @(posedge clk_i) begin
    if (pop && fire) begin
      kind_q     <= kind_d;
      o_width_q  <= o_width_d;
      o_height_q <= o_height_d;
      o_maxval_q <= o_maxval_d;
      o_row_q    <= o_row_d;
      o_col_q    <= o_col_d;
      o_red_q    <= o_red_d;
      o_green_q  <= o_green_d;
      o_blue_q   <= o_blue_d;
      o_mask_q   <= o_mask_d;
      o_last_q   <= o_last_d;
      o_err_q    <= o_err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.image_width  = o_width_q;
  assign out_o.image_height = o_height_q;
  assign out_o.max_value    = o_maxval_q;
  assign out_o.pixel_row    = o_row_q;
  assign out_o.pixel_column = o_col_q;
  assign out_o.red          = o_red_q;
  assign out_o.green        = o_green_q;
  assign out_o.blue         = o_blue_q;
  assign out_o.keep_mask    = o_mask_q;
  assign out_o.last_pixel   = o_last_q;
  assign out_o.error_code   = o_err_q;

endmodule

/* src/ppm_p6_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser
// Parses a binary PPM (P6) byte stream into a header result, pixel results
// and error results.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the output register is free
// or draining and gives at most one result per byte. A byte is classified as
// it is accepted and written into a two-entry queue; the parser state machine
// takes one byte per cycle from the queue under the same condition and writes
// any result into the output register, so a byte passes through the queue and
// then the output register before its result is presented. The parser state
// machine, which handles a single byte in each cycle, sets the sustained rate.
// While the output register holds a result that is not taken, the queue absorbs
// up to two further bytes before the input stalls. A byte with restart set
// returns the parser to the start of a new file before the byte itself is parsed.
// After an error or the last pixel, bytes are taken and dropped until a restart.
module ppm_p6_stream_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppsp_in_if.sink    in_i,
  ppsp_out_if.source out_o
);

  logic                push_valid, push_ready;
  ppsp_pkg::byte_cls_t push_data;
  logic                pop_valid, pop_ready;
  ppsp_pkg::byte_cls_t pop_data;

  // Byte acceptance and classification.
  ppsp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Decoupling queue.
  ppsp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // Parser and result register.
  ppsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// PPM P6 stream parser testbench
// Feeds byte streams into the parser: a short run of hand-written files, then
// random files that are mostly well formed, some with a damaged byte, and
// bursts of noise. An in-bench model of the parser predicts every header,
// pixel and error result, and a clocked checker compares each transfer on the
// result channel with the oldest prediction. Both channels stall at random,
// and the receiver holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One input transfer.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } stim_byte_t;

  // One result transfer, field by field.
  typedef struct packed {
    ppsp_pkg::kind_e kind;
    logic [12:0]     width;
    logic [12:0]     height;
    logic [7:0]      maxv;
    logic [11:0]     row;
    logic [11:0]     col;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [2:0]      mask;
    logic            last;
    ppsp_pkg::err_e  err;
  } parse_result_t;

  localparam int unsigned RandomBytes = 850;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;

  ppsp_in_if  in_if ();
  ppsp_out_if out_if ();

  ppm_p6_stream_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and expectations.
  stim_byte_t    pending_bytes[$];
  logic [7:0]    file_buf[$];
  parse_result_t expected_results[$];
  int unsigned   total_bytes;
  int unsigned   bytes_taken;
  int unsigned   fail_cnt;
  int unsigned   headers_seen;
  int unsigned   pixels_seen;
  int unsigned   errors_seen;
  int unsigned   hold_left;
  bit            hold_done;

  // Parser state as the block should hold it.
  ppsp_pkg::phase_e prs_phase;
  int unsigned      num_acc;
  bit               num_neg;
  int unsigned      img_w;
  int unsigned      img_h;
  int unsigned      img_max;
  int unsigned      row_cnt;
  int unsigned      col_cnt;
  int unsigned      chan_idx;
  logic [7:0]       held_r;
  logic [7:0]       held_g;

  // Clock.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------

  function automatic bit is_space(input logic [7:0] b);
    return b == ppsp_pkg::ChSpace || (b >= ppsp_pkg::ChTab && b <= ppsp_pkg::ChCr);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= ppsp_pkg::ChZero && b <= ppsp_pkg::ChNine;
  endfunction

  function automatic void clear_parser();
    prs_phase = ppsp_pkg::PH_MAG_P;
    num_acc   = 0;
    num_neg   = 1'b0;
    img_w     = 0;
    img_h     = 0;
    img_max   = 1;
    row_cnt   = 0;
    col_cnt   = 0;
    chan_idx  = 0;
    held_r    = '0;
    held_g    = '0;
  endfunction

  // The phases of the three header numbers are consecutive one-hot codes:
  // start, sign seen, digits seen, for width, height and maximum in turn.
  function automatic ppsp_pkg::phase_e field_phase(input int unsigned fld,
                                                   input int unsigned sub);
    logic [13:0] code;
    code = ppsp_pkg::PH_W_START;
    code = code << (3 * fld + sub);
    return ppsp_pkg::phase_e'(code);
  endfunction

  function automatic bit raise_error(input ppsp_pkg::err_e code, output parse_result_t res);
    res       = '0;
    res.kind  = ppsp_pkg::KIND_ERROR;
    res.err   = code;
    prs_phase = ppsp_pkg::PH_HALT;
    return 1'b1;
  endfunction

  // First byte of a header number, or whitespace in front of it.
  function automatic bit start_field(input int unsigned fld, input logic [7:0] b,
                                     output parse_result_t res);
    res = '0;
    if (is_space(b)) begin
      prs_phase = field_phase(fld, 0);
      return 1'b0;
    end
    if (b == ppsp_pkg::ChPlus || b == ppsp_pkg::ChMinus) begin
      num_neg   = (b == ppsp_pkg::ChMinus);
      num_acc   = 0;
      prs_phase = field_phase(fld, 1);
      return 1'b0;
    end
    if (is_digit(b)) begin
      num_neg   = 1'b0;
      num_acc   = b - ppsp_pkg::ChZero;
      prs_phase = field_phase(fld, 2);
      return 1'b0;
    end
    return raise_error(ppsp_pkg::ERR_NUMBER, res);
  endfunction

  // Advances the parser by one byte; returns 1 when the byte gives a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic rs,
                                    output parse_result_t res);
    logic [13:0] code;
    int unsigned pos;
    int unsigned fld;
    int unsigned sub;
    int unsigned acc;
    bit          last;
    res = '0;
    if (rs) clear_parser();
    case (prs_phase)
      ppsp_pkg::PH_MAG_P: begin
        if (is_space(b)) return 1'b0;
        if (b == ppsp_pkg::ChP) begin
          prs_phase = ppsp_pkg::PH_MAG_6;
          return 1'b0;
        end
        return raise_error(ppsp_pkg::ERR_MAGIC, res);
      end
      ppsp_pkg::PH_MAG_6: begin
        if (b == ppsp_pkg::ChSix) begin
          prs_phase = ppsp_pkg::PH_MAG_END;
          return 1'b0;
        end
        return raise_error(ppsp_pkg::ERR_MAGIC, res);
      end
      ppsp_pkg::PH_MAG_END: begin
        if (is_space(b)) begin
          prs_phase = ppsp_pkg::PH_W_START;
          return 1'b0;
        end
        return raise_error(ppsp_pkg::ERR_MAGIC, res);
      end
      ppsp_pkg::PH_PIXEL: begin
        if (chan_idx == 0) begin
          held_r   = b;
          chan_idx = 1;
          return 1'b0;
        end
        if (chan_idx == 1) begin
          held_g   = b;
          chan_idx = 2;
          return 1'b0;
        end
        last       = (row_cnt + 1 >= img_h) && (col_cnt + 1 >= img_w);
        res.kind   = ppsp_pkg::KIND_PIXEL;
        res.width  = 13'(img_w);
        res.height = 13'(img_h);
        res.maxv   = 8'(img_max);
        res.row    = 12'(row_cnt);
        res.col    = 12'(col_cnt);
        res.red    = held_r;
        res.green  = held_g;
        res.blue   = b;
        res.mask   = {b <= img_max, held_g <= img_max, held_r <= img_max};
        res.last   = last;
        chan_idx   = 0;
        if (last) begin
          prs_phase = ppsp_pkg::PH_HALT;
        end else if (col_cnt + 1 >= img_w) begin
          col_cnt = 0;
          row_cnt++;
        end else begin
          col_cnt++;
        end
        return 1'b1;
      end
      ppsp_pkg::PH_HALT: return 1'b0;
      default: begin
        // One of the nine header number phases.
        code = prs_phase;
        pos  = 0;
        for (int i = 0; i < 14; i++) if (code[i]) pos = i;
        fld = (pos - 3) / 3;
        sub = (pos - 3) % 3;
        if (sub == 0) return start_field(fld, b, res);
        if (is_digit(b)) begin
          acc       = num_acc * 10 + (b - ppsp_pkg::ChZero);
          num_acc   = (acc > ppsp_pkg::NumCap) ? ppsp_pkg::NumCap : acc;
          prs_phase = field_phase(fld, 2);
          return 1'b0;
        end
        if (sub == 1) return raise_error(ppsp_pkg::ERR_NUMBER, res);
        if (fld < 2) begin
          if (num_neg || num_acc == 0 || num_acc > ppsp_pkg::MaxDim)
            return raise_error(ppsp_pkg::ERR_NUMBER, res);
          if (fld == 0) img_w = num_acc;
          else img_h = num_acc;
          // The byte that ends a size starts the next number.
          return start_field(fld + 1, b, res);
        end
        if (num_neg || num_acc == 0 || num_acc > ppsp_pkg::MaxColour)
          return raise_error(ppsp_pkg::ERR_MAXVAL, res);
        img_max    = num_acc;
        row_cnt    = 0;
        col_cnt    = 0;
        chan_idx   = 0;
        prs_phase  = ppsp_pkg::PH_PIXEL;
        res.kind   = ppsp_pkg::KIND_HEADER;
        res.width  = 13'(img_w);
        res.height = 13'(img_h);
        res.maxv   = 8'(img_max);
        return 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endfunction

  task automatic add_space(input int unsigned lo, input int unsigned hi);
    logic [7:0] space_set [6];
    int unsigned n;
    space_set = '{ppsp_pkg::ChSpace, ppsp_pkg::ChTab, 8'h0A, 8'h0B, 8'h0C, ppsp_pkg::ChCr};
    n = $urandom_range(hi, lo);
    repeat (n) file_buf.push_back(space_set[$urandom_range(5, 0)]);
  endtask

  // Appends one header number in a random form. Returns its value when the
  // parser should take it, 0 when it should be rejected. A joined number
  // carries its own sign straight after the previous number.
  function automatic int unsigned add_field(input bit colour, input bit joined);
    int unsigned pick;
    int unsigned mag;
    bit          good;
    pick = $urandom_range(99, 0);
    good = 1'b1;
    if (joined) begin
      good = 1'($urandom_range(1, 0));
      file_buf.push_back(good ? ppsp_pkg::ChPlus : ppsp_pkg::ChMinus);
      mag = $urandom_range(3, 1);
    end else if (pick < 68) begin
      mag = colour ? $urandom_range(ppsp_pkg::MaxColour, 1) : $urandom_range(3, 1);
    end else if (pick < 75) begin
      // Largest accepted value, or the smallest maximum.
      mag = colour ? ($urandom_range(1, 0) ? ppsp_pkg::MaxColour : 1) : ppsp_pkg::MaxDim;
    end else if (pick < 80) begin
      mag  = colour ? ppsp_pkg::MaxColour + 1 : ppsp_pkg::MaxDim + 1;
      good = 1'b0;
    end else if (pick < 84) begin
      // Long enough to saturate the magnitude.
      mag  = $urandom_range(99999999, 10000);
      good = 1'b0;
    end else if (pick < 88) begin
      mag  = 0;
      good = 1'b0;
    end else if (pick < 92) begin
      file_buf.push_back(ppsp_pkg::ChMinus);
      mag  = $urandom_range(9, 1);
      good = 1'b0;
    end else if (pick < 95) begin
      // Sign with no digit after it.
      file_buf.push_back($urandom_range(1, 0) ? ppsp_pkg::ChPlus : ppsp_pkg::ChMinus);
      return 0;
    end else begin
      file_buf.push_back(ppsp_pkg::ChPlus);
      mag = colour ? $urandom_range(ppsp_pkg::MaxColour, 1) : $urandom_range(3, 1);
    end
    if ($urandom_range(9, 0) == 0) add_text("00");
    add_text($sformatf("%0d", mag));
    return good ? mag : 0;
  endfunction

  task automatic add_file();
    int unsigned w;
    int unsigned h;
    longint unsigned area;
    int unsigned npix;
    logic [7:0] sep;
    bit joined;
    add_space(0, 2);
    add_text("P6");
    add_space(1, 2);
    w = add_field(1'b0, 1'b0);
    joined = ($urandom_range(6, 0) == 0);
    if (!joined) add_space(1, 2);
    h = add_field(1'b0, joined);
    add_space(1, 2);
    void'(add_field(1'b1, 1'b0));
    // Any non-digit byte ends the maximum and is eaten as the separator.
    if ($urandom_range(1, 0)) begin
      sep = 8'h0A;
    end else begin
      do sep = 8'($urandom_range(255, 0)); while (is_digit(sep));
    end
    file_buf.push_back(sep);
    area = longint'(w) * longint'(h);
    if (area == 0) npix = $urandom_range(3, 1);
    else if (area > 9) npix = $urandom_range(9, 1);
    else if ($urandom_range(6, 0) == 0) npix = $urandom_range(32'(area), 0);
    else npix = 32'(area);
    repeat (3 * npix) file_buf.push_back(8'($urandom_range(255, 0)));
    repeat ($urandom_range(2, 0)) file_buf.push_back(8'($urandom_range(255, 0)));
  endtask

  task automatic add_noise();
    if ($urandom_range(1, 0)) file_buf.push_back(ppsp_pkg::ChP);
    if ($urandom_range(1, 0)) file_buf.push_back(ppsp_pkg::ChSix);
    repeat ($urandom_range(8, 2)) file_buf.push_back(8'($urandom_range(255, 0)));
  endtask

  // Moves the gathered bytes to the driver, restart on the first if asked.
  task automatic flush_file(input bit rs);
    stim_byte_t item;
    for (int i = 0; i < file_buf.size(); i++) begin
      item.data    = file_buf[i];
      item.restart = rs && (i == 0);
      pending_bytes.push_back(item);
    end
    file_buf.delete();
  endtask

  // Chance of a stall: the sender first idles less, then the receiver does,
  // and in the last third neither does.
  function automatic bit idle_draw(input bit sender);
    int unsigned pct;
    if (bytes_taken < total_bytes / 3) pct = sender ? 18 : 46;
    else if (bytes_taken < 2 * total_bytes / 3) pct = sender ? 46 : 18;
    else pct = 0;
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic string show(input parse_result_t r);
    return $sformatf({"kind=%0d w=%0d h=%0d max=%0d row=%0d col=%0d ",
                      "rgb=%0d/%0d/%0d mask=%b last=%b err=%0d"},
                     r.kind, r.width, r.height, r.maxv, r.row, r.col,
                     r.red, r.green, r.blue, r.mask, r.last, r.err);
  endfunction

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers pending bytes and predicts on every accepted transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stim_byte_t    nxt;
    parse_result_t res;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
      in_if.restart <= 1'b0;
      clear_parser();
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (parse_byte(in_if.in_byte, in_if.restart, res)) expected_results.push_back(res);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        // The sender keeps offering while the receiver is held off.
        if (pending_bytes.size() != 0 && (hold_left != 0 || !idle_draw(1'b1))) begin
          nxt = pending_bytes.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= nxt.data;
          in_if.restart <= nxt.restart;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, halfway through the run.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= total_bytes / 2) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    parse_result_t got;
    parse_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.kind   = ppsp_pkg::kind_e'(out_if.result_kind);
        got.width  = out_if.image_width;
        got.height = out_if.image_height;
        got.maxv   = out_if.max_value;
        got.row    = out_if.pixel_row;
        got.col    = out_if.pixel_column;
        got.red    = out_if.red;
        got.green  = out_if.green;
        got.blue   = out_if.blue;
        got.mask   = out_if.keep_mask;
        got.last   = out_if.last_pixel;
        got.err    = ppsp_pkg::err_e'(out_if.error_code);
        case (got.kind)
          ppsp_pkg::KIND_HEADER: headers_seen++;
          ppsp_pkg::KIND_PIXEL:  pixels_seen++;
          default:               errors_seen++;
        endcase
        if (expected_results.size() == 0) begin
          note_failure({"result with nothing expected: ", show(got)});
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            note_failure({"result mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
        end
      end
      out_if.ready <= (hold_left == 0) && !idle_draw(1'b0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int unsigned waited;
    int unsigned pick;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    bytes_taken   = 0;
    fail_cnt      = 0;
    headers_seen  = 0;
    pixels_seen   = 0;
    errors_seen   = 0;

    // Width ending at the sign of the height, a 2x1 image with channel bytes
    // at both extremes and above the maximum, then a byte after the last
    // pixel that must be dropped.
    add_text("P6 2+1 9");
    file_buf.push_back(ppsp_pkg::ChCr);
    file_buf.push_back(8'd9);
    file_buf.push_back(8'd10);
    file_buf.push_back(8'd0);
    file_buf.push_back(8'd255);
    file_buf.push_back(8'd9);
    file_buf.push_back(8'd8);
    add_text("Z");
    flush_file(1'b1);
    // Bad magic, then a zero maximum.
    add_text("X");
    flush_file(1'b1);
    add_text("P6 1 1 0 ");
    flush_file(1'b1);

    // Random files: mostly well formed, some damaged, some noise.
    total_bytes = pending_bytes.size() + RandomBytes;
    while (pending_bytes.size() < total_bytes) begin
      pick = $urandom_range(99, 0);
      if (pick < 88) begin
        add_file();
        if (pick >= 72)
          file_buf[$urandom_range(file_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
        flush_file(1'b1);
      end else begin
        add_noise();
        flush_file($urandom_range(3, 0) != 0);
      end
    end
    total_bytes = pending_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk_i);
    waited = 0;
    while (expected_results.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    while (expected_results.size() != 0)
      note_failure({"result never arrived: ", show(expected_results.pop_front())});
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input bytes and checked %0d headers, %0d pixels, %0d errors.",
             total_bytes, headers_seen, pixels_seen, errors_seen);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures in total.", fail_cnt);
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #500000;
    $display("Run stopped by the watchdog.");
    $display("simulation failed");
    $finish;
  end

endmodule
